>>> src/aes128_cbc_encrypt_defines.svh
// ----------------------------------------------------------------------------
// AES-128 CBC encrypt: assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AES128_CBC_ENCRYPT_DEFINES_SVH
`define AES128_CBC_ENCRYPT_DEFINES_SVH
`ifndef SYNTH
`define AES_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define AES_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define AES_ASSERT_IMP(label, clk, rst_n, a, c)
`define AES_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> src/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// S-box, GF(2^8) helpers and round/key-step functions.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned BLK_W = 128;

    typedef logic [127:0] t_blk;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_IV_HIGH  = 2'd2,
        REG_IV_LOW   = 2'd3
    } t_reg_idx;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON_FIRST = 8'h01;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input t_blk s, input int unsigned i);
        get_byte = s[127 - 8 * i -: 8];
    endfunction

    function automatic t_blk sub_shift(input t_blk s);
        t_blk t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] =
                    SBOX[get_byte(s, 32'(r + 4 * ((c + r) % 4)))];
            end
        end
        sub_shift = t;
    endfunction

    function automatic t_blk mix_cols(input t_blk s);
        t_blk t;
        logic [7:0] a0, a1, a2, a3, al;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 32'(4 * c));
            a1 = get_byte(s, 32'(4 * c + 1));
            a2 = get_byte(s, 32'(4 * c + 2));
            a3 = get_byte(s, 32'(4 * c + 3));
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
        end
        mix_cols = t;
    endfunction

    // next round key from previous one
    function automatic t_blk key_step(input t_blk k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_step = {w0, w1, w2, w3};
    endfunction

endpackage

>>> src/aes_round.sv
// ----------------------------------------------------------------------------
// AES round unit
// One shared round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// ----------------------------------------------------------------------------
module aes_round (
    input  aes_pkg::t_blk i_state,
    input  aes_pkg::t_blk i_key,
    input  logic          i_last,
    output aes_pkg::t_blk o_state
);
    aes_pkg::t_blk w_ss;

    always_comb begin
        w_ss = aes_pkg::sub_shift(i_state);
        o_state = (i_last ? w_ss : aes_pkg::mix_cols(w_ss)) ^ i_key;
    end
endmodule

>>> src/aes128_cbc_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 CBC encrypt
// Each request is worked in steps: first the chaining XOR and first key
// addition, then one round per cycle through a single shared round unit, with
// the round key computed on the fly alongside it. The block is then handed to
// the output register, and a new request is taken only after that, so requests
// never overlap. The core stalls, holding its result, only while the output
// register still waits to be taken.
// Key and IV registers are sampled at the start of a message only.
// ----------------------------------------------------------------------------
`include "aes128_cbc_encrypt_defines.svh"

module aes128_cbc_encrypt #(
    parameter int unsigned NUM_ROUNDS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] plaintext_high, [127:64] plaintext_low
    input  logic         s_axis_tuser,   // start_of_message
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] ciphertext_high, [127:64] ciphertext_low
);
    localparam int unsigned CW = $clog2(NUM_ROUNDS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_rnd, n_rnd;
    logic [63:0]   r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    aes_pkg::t_blk r_base_key, r_key, n_key;
    aes_pkg::t_blk r_chain, n_chain;
    aes_pkg::t_blk r_s, n_s;
    aes_pkg::t_blk r_out;
    logic          r_out_vld;
    logic [7:0]    r_rc, n_rc;
    logic          r_open, n_open;
    aes_pkg::t_blk w_round, w_nkey, w_in, w_k0, w_c0;
    logic          w_acc, w_restart, w_ofree, w_load;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out[63:0], r_out[127:64]};
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_ofree       = !r_out_vld || m_axis_tready;
    assign w_load        = (r_state == ST_OUT) && w_ofree;
    assign w_restart     = s_axis_tuser || !r_open;
    assign w_in          = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign w_k0          = w_restart ? {r_key_hi, r_key_lo} : r_base_key;
    assign w_c0          = w_restart ? {r_iv_hi, r_iv_lo} : r_chain;
    assign w_nkey        = aes_pkg::key_step(r_key, r_rc);

    aes_round u_round (
        .i_state (r_s),
        .i_key   (w_nkey),
        .i_last  (r_rnd == CW'(NUM_ROUNDS)),
        .o_state (w_round)
    );

    always_ff @(posedge i_clk) begin
        if (i_cfg_valid) begin
            unique case (aes_pkg::t_reg_idx'(i_cfg_index))
                aes_pkg::REG_KEY_HIGH: r_key_hi <= i_cfg_data;
                aes_pkg::REG_KEY_LOW:  r_key_lo <= i_cfg_data;
                aes_pkg::REG_IV_HIGH:  r_iv_hi  <= i_cfg_data;
                aes_pkg::REG_IV_LOW:   r_iv_lo  <= i_cfg_data;
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_iv_hi  <= '0;
            r_iv_lo  <= '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_key   = r_key;
        n_chain = r_chain;
        n_s     = r_s;
        n_rc    = r_rc;
        n_open  = r_open;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_key   = w_k0;
                    n_s     = w_in ^ w_c0 ^ w_k0;
                    n_rc    = aes_pkg::RCON_FIRST;
                    n_rnd   = CW'(1);
                    n_open  = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_s   = w_round;
                n_key = w_nkey;
                n_rc  = aes_pkg::xtime(r_rc);
                if (r_rnd == CW'(NUM_ROUNDS)) begin
                    n_chain = w_round;
                    n_state = ST_OUT;
                end else begin
                    n_rnd = r_rnd + CW'(1);
                end
            end
            ST_OUT: begin
                if (w_ofree) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_s   <= n_s;
        r_rc  <= n_rc;
        r_rnd <= n_rnd;
        if (w_acc) r_base_key <= w_k0;
        if (w_load) r_out <= r_s;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chain   <= '0;
            r_open    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chain <= n_chain;
            r_open  <= n_open;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    `AES_ASSERT_NXT(a_acc_runs, i_clk, i_rst_n, w_acc, r_state == ST_RUN && r_rnd == CW'(1))
    `AES_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `AES_ASSERT_IMP(a_rnd_range, i_clk, i_rst_n, r_state == ST_RUN, r_rnd != '0)
    `AES_ASSERT_NXT(a_open_kept, i_clk, i_rst_n, r_open, r_open)
endmodule

>>> test/aes_cbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CBC encrypt: stream checker
// Watches the register, plaintext and ciphertext channels. It keeps its own
// key, IV and chaining state and works out the ciphertext of each accepted
// request. Each returned block is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module aes_cbc_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_pt_valid,
    input  logic         i_pt_ready,
    input  logic [127:0] i_pt_data,
    input  logic         i_pt_start,
    input  logic         i_ct_valid,
    input  logic         i_ct_ready,
    input  logic [127:0] i_ct_data,
    output int           o_errors,
    output int           o_pending
);
    logic [7:0]   sbox [256];
    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic [127:0] chain;
    logic [127:0] rkey [11];
    logic         msg_open;
    logic [127:0] ct_expected [$];

    function automatic logic [7:0] dbl(input logic [7:0] b);
        dbl = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = dbl(a);
        end
        gf_mul = p;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] b, input int n);
        rol8 = (b << n) | (b >> (8 - n));
    endfunction

    // S-box from the field inverse and the affine map
    initial begin
        logic [7:0] inv;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gf_mul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
            sbox[a] = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4)
                      ^ 8'h63;
        end
    end

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        byte_at = s[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] subst_rows(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (r + 4 * c) -: 8] = sbox[byte_at(s, r + 4 * ((c + r) % 4))];
        subst_rows = t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a [4];
        logic [7:0]   x;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = byte_at(s, 4 * c + r);
            x = a[0] ^ a[1] ^ a[2] ^ a[3];
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * c + r) -: 8] = a[r] ^ x ^ dbl(a[r] ^ a[(r + 1) % 4]);
        end
        mix_columns = t;
    endfunction

    task automatic build_key_schedule();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
        for (int i = 4; i < 44; i++) begin
            t = w[i - 1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sbox[t[31:24]] ^ rc, sbox[t[23:16]], sbox[t[15:8]], sbox[t[7:0]]};
                rc = dbl(rc);
            end
            w[i] = w[i - 4] ^ t;
        end
        for (int r = 0; r < 11; r++)
            rkey[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    endtask

    task automatic encrypt_block(input logic [127:0] pt, input logic start);
        logic [127:0] s;
        if (start || !msg_open) begin
            build_key_schedule();
            chain = {iv_hi, iv_lo};
            msg_open = 1'b1;
        end
        s = (pt ^ chain) ^ rkey[0];
        for (int r = 1; r < 10; r++) s = mix_columns(subst_rows(s)) ^ rkey[r];
        s = subst_rows(s) ^ rkey[10];
        chain = s;
        ct_expected = {ct_expected, s};
    endtask

    always @(posedge i_clk) begin
        logic [127:0] ct;
        int           bad_cnt;
        bad_cnt = 0;
        if (!i_rst_n) begin
            key_hi   <= '0;
            key_lo   <= '0;
            iv_hi    <= '0;
            iv_lo    <= '0;
            chain    = '0;
            msg_open = 1'b0;
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (aes_pkg::t_reg_idx'(i_cfg_index))
                    aes_pkg::REG_KEY_HIGH: key_hi <= i_cfg_data;
                    aes_pkg::REG_KEY_LOW:  key_lo <= i_cfg_data;
                    aes_pkg::REG_IV_HIGH:  iv_hi  <= i_cfg_data;
                    aes_pkg::REG_IV_LOW:   iv_lo  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pt_valid && i_pt_ready)
                encrypt_block({i_pt_data[63:0], i_pt_data[127:64]}, i_pt_start);
            if (i_ct_valid && i_ct_ready) begin
                if (ct_expected.size() == 0) begin
                    $error("unexpected ciphertext %h", i_ct_data);
                    bad_cnt++;
                end else begin
                    ct = ct_expected.pop_front();
                    if (i_ct_data[63:0] !== ct[127:64]) begin
                        $error("ciphertext_high: expected %h, got %h", ct[127:64],
                               i_ct_data[63:0]);
                        bad_cnt++;
                    end
                    if (i_ct_data[127:64] !== ct[63:0]) begin
                        $error("ciphertext_low: expected %h, got %h", ct[63:0],
                               i_ct_data[127:64]);
                        bad_cnt++;
                    end
                end
            end
            o_errors <= o_errors + bad_cnt;
        end
        o_pending <= ct_expected.size();
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CBC encrypt: testbench top
// Directed known-answer and extreme blocks, then random messages under
// random key and IV settings, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    int           errors, pending;
    logic         no_gaps = 1'b0;

    always #1 i_clk = ~i_clk;

    aes128_cbc_encrypt u_top (.*);

    aes_cbc_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_pt_valid (s_axis_tvalid),
        .i_pt_ready (s_axis_tready),
        .i_pt_data  (s_axis_tdata),
        .i_pt_start (s_axis_tuser),
        .i_ct_valid (m_axis_tvalid),
        .i_ct_ready (m_axis_tready),
        .i_ct_data  (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 32);
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0: rand_word = '0;
            1: rand_word = '1;
            default: rand_word = {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic start);
        while (!no_gaps && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        s_axis_tuser  <= start;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
    endtask

    // lets every request come out and the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (14) @(posedge i_clk);
    endtask

    task automatic write_reg(input aes_pkg::t_reg_idx idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [63:0] kh, input logic [63:0] kl,
                            input logic [63:0] vh, input logic [63:0] vl);
        write_reg(aes_pkg::REG_KEY_HIGH, kh);
        write_reg(aes_pkg::REG_KEY_LOW, kl);
        write_reg(aes_pkg::REG_IV_HIGH, vh);
        write_reg(aes_pkg::REG_IV_LOW, vl);
    endtask

    initial begin
        int sent, len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first request after reset restarts without the start flag
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b0);
        drain();
        set_regs(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_block('0, '0, 1'b0);
        drain();
        // new registers only take hold at a restart
        set_regs('1, '1, '1, '1);
        send_block('1, '0, 1'b0);
        send_block('0, '1, 1'b1);
        send_block('1, '1, 1'b0);
        send_block(64'h8000000000000001, 64'h0000000180000000, 1'b0);
        drain();
        set_regs('0, '0, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1);

        sent = 0;
        while (sent < 1850) begin
            drain();
            if ($urandom_range(3) != 0)
                set_regs(rand_word(), rand_word(), rand_word(), rand_word());
            else
                write_reg(aes_pkg::t_reg_idx'($urandom_range(3)), rand_word());
            no_gaps = (sent >= 900 && sent < 1000);
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                send_block(rand_word(), rand_word(),
                           i == 0 ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
                if ($urandom_range(99) == 0) drain();
            end
            sent += len;
        end
        no_gaps = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("[aes128_cbc_encrypt] OK");
        end else begin
            $display("[aes128_cbc_encrypt] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[aes128_cbc_encrypt] ERROR");
        $finish;
    end

endmodule
